// File: src/tks_pkg.sv
// shared types, constants and compare function for the top-k select block
`timescale 1ns / 1ps

package tks_pkg;

  localparam int CAPACITY = 64;
  localparam int VALUE_W  = 32;
  localparam int K_W      = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_WANT_LARGEST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT   = 2'd1;

  // broadcast to every cell
  typedef struct packed {
    logic                      clear;
    logic                      insert;
    logic                      shift;
    logic                      largest;
    logic signed [VALUE_W-1:0] sample;
  } cell_ctrl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                      valid;
    logic                      beaten;
    logic signed [VALUE_W-1:0] value;
  } cell_link_t;

  // true when a is strictly better than b
  function automatic logic beats(input logic largest,
                                 input logic signed [VALUE_W-1:0] a,
                                 input logic signed [VALUE_W-1:0] b);
    beats = largest ? (a > b) : (a < b);
  endfunction

endpackage

// File: src/tks_sample_if.sv
// input channel: one sample value with end-of-set flag
`timescale 1ns / 1ps

interface tks_sample_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [tks_pkg::VALUE_W-1:0]         sample_value;
  logic                                       set_end;

  modport source (output valid, output sample_value, output set_end, input ready);
  modport sink   (input valid, input sample_value, input set_end, output ready);
endinterface

// File: src/tks_rank_if.sv
// output channel: one ranked value with final flag
`timescale 1ns / 1ps

interface tks_rank_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [tks_pkg::VALUE_W-1:0]         ranked_value;
  logic                                       final_flag;

  modport source (output valid, output ranked_value, output final_flag, input ready);
  modport sink   (input valid, input ranked_value, input final_flag, output ready);
endinterface

// File: src/tks_cell.sv
// one slot of the sorted chain: insert by compare, shift toward the head on drain
`timescale 1ns / 1ps

module tks_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                enable,
  input  tks_pkg::cell_ctrl_t ctrl,
  input  tks_pkg::cell_link_t prev,
  input  tks_pkg::cell_link_t next,
  output tks_pkg::cell_link_t link
);

  logic                               valid;
  logic signed [tks_pkg::VALUE_W-1:0] value;
  logic                               beaten;

  assign beaten = valid && tks_pkg::beats(ctrl.largest, ctrl.sample, value);

  assign link.valid  = valid;
  assign link.beaten = beaten;
  assign link.value  = value;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= next.valid;
    end else if (ctrl.insert && enable) begin
      if (prev.beaten) begin
        valid <= 1'b1;
      end else if (prev.valid && (!valid || beaten)) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= next.value;
    end else if (ctrl.insert && enable) begin
      if (prev.beaten) begin
        // new item lands above us, push our upper neighbor down
        value <= prev.value;
      end else if (prev.valid && (!valid || beaten)) begin
        value <= ctrl.sample;
      end
    end
  end

endmodule

// File: src/streaming_top_k_select_unit.sv
// top level of the streaming top-k select block
//
// usage: items arrive on the sample channel (valid/ready), one value each,
// with set_end on the last value of a set. the block keeps the best k values
// (largest or smallest, per want_largest) in a chain of 64 sorted cells.
// every cell compares the incoming value with its own in the same cycle, so
// one item is taken per clock while a set streams in.
// after the item carrying set_end, the chain drains through cell 0 onto the
// ranked channel, best first, one result per cycle, final_flag on the last.
// the drain closes once cell 0 shows empty after the last result is taken;
// sample ready is low for that whole drain. with k zero it gives nothing.
// when the receiver stalls, cell 0 holds the current result and the chain
// does not move until it is taken.
// config writes (want_largest index 0, keep_count index 1) discard any
// partial set; keep_count above 64 acts as 64.
// reset (rst, synchronous) empties the chain, sets want_largest to 1 and
// keep_count to 64. no clearing pass is needed.
`timescale 1ns / 1ps

module streaming_top_k_select_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tks_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tks_pkg::CFG_DATA_W-1:0]   cfg_data,
  tks_sample_if.sink                       sample,
  tks_rank_if.source                       ranked
);

  localparam int N = tks_pkg::CAPACITY;

  logic                    largest;
  logic [tks_pkg::K_W-1:0] k_eff;
  logic                    draining;
  logic                    cfg_hit;
  logic                    in_take;
  logic                    out_take;
  logic [N-1:0]            valid_vec;

  tks_pkg::cell_ctrl_t ctrl;
  tks_pkg::cell_link_t links [N];
  tks_pkg::cell_link_t head_prev;
  tks_pkg::cell_link_t tail_next;

  assign cfg_hit = cfg_we && (cfg_index == tks_pkg::CFG_WANT_LARGEST ||
                              cfg_index == tks_pkg::CFG_KEEP_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      largest <= 1'b1;
      k_eff   <= tks_pkg::K_W'(N);
    end else if (cfg_we) begin
      case (cfg_index)
        tks_pkg::CFG_WANT_LARGEST: largest <= cfg_data[0];
        tks_pkg::CFG_KEEP_COUNT: begin
          if (cfg_data[tks_pkg::K_W-1:0] > tks_pkg::K_W'(N)) begin
            k_eff <= tks_pkg::K_W'(N);
          end else begin
            k_eff <= cfg_data[tks_pkg::K_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign sample.ready = !draining;
  assign in_take      = sample.valid && sample.ready;
  assign out_take     = ranked.valid && ranked.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
    end else if (in_take && sample.set_end) begin
      draining <= 1'b1;
    end else if (draining && !links[0].valid) begin
      draining <= 1'b0;
    end
  end

  assign ctrl.clear   = cfg_hit;
  assign ctrl.insert  = in_take;
  assign ctrl.shift   = out_take;
  assign ctrl.largest = largest;
  assign ctrl.sample  = sample.sample_value;

  // the head sees a full, never-beaten neighbor above it
  assign head_prev.valid  = 1'b1;
  assign head_prev.beaten = 1'b0;
  assign head_prev.value  = '0;

  assign tail_next.valid  = 1'b0;
  assign tail_next.beaten = 1'b0;
  assign tail_next.value  = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    tks_pkg::cell_link_t prev_l;
    tks_pkg::cell_link_t next_l;
    if (i == 0) begin : g_head
      assign prev_l = head_prev;
    end else begin : g_body
      assign prev_l = links[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign next_l = tail_next;
    end else begin : g_mid
      assign next_l = links[i+1];
    end
    tks_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .enable (tks_pkg::K_W'(i) < k_eff),
      .ctrl   (ctrl),
      .prev   (prev_l),
      .next   (next_l),
      .link   (links[i])
    );
    assign valid_vec[i] = links[i].valid;
  end

  assign ranked.valid        = draining && links[0].valid;
  assign ranked.ranked_value = links[0].value;
  if (N > 1) begin : g_final_multi
    assign ranked.final_flag = !links[1].valid;
  end else begin : g_final_single
    assign ranked.final_flag = 1'b1;
  end

  // occupied cells always form a prefix of the chain
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, valid_vec} + (N+1)'(1)))
    else $error("valid cells not contiguous from head");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) <= k_eff)
    else $error("more values kept than k");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    in_take && sample.set_end && !cfg_hit |=> draining)
    else $error("set end did not start drain");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_take && !ranked.final_flag && !cfg_hit |=>
      ranked.valid && !tks_pkg::beats(largest, ranked.ranked_value,
                                      $past(ranked.ranked_value)))
    else $error("results not emitted best first");

endmodule
